/* sv/multicore_round_robin_scheduler_unit_defines.svh */
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms for the round-robin scheduler.
// ----------------------------------------------------------------------------
`ifndef MULTICORE_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define MULTICORE_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MRRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mrrs_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Event codes, register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrrs_pkg;

  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_UNBLOCK = 3'd1,
    KIND_TICK    = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_EXIT    = 3'd4
  } kind_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CORES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_QUANTUM = 2'd1;

  localparam logic [2:0]  CORES_RESET   = 3'd4;
  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LOAD_WR,
    S_MAP,
    S_UNBLK,
    S_CORE,
    S_RES
  } state_e;

endpackage

`default_nettype wire

/* sv/multicore_round_robin_scheduler_unit.sv */
// Per-core round-robin scheduler. After reset the block sweeps the task-to-core
// table and takes no event meanwhile; configuration writes are taken at any
// time. Events are then handled one at a time: a load runs a scan that reads one
// core record per cycle from the core state memory, over each core in use, then
// a write; an unblock does a table read, a core record read and a queue write;
// tick, block and exit do a core record read, a queue read and a result
// register, which waits on out_stall_i; an event for an absent core or of an
// unknown kind goes straight to the result register. The next event is taken
// while a result still waits.
// ----------------------------------------------------------------------------
// Multicore round-robin scheduler unit
// Per-core ready queues, least-loaded placement and quantum tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multicore_round_robin_scheduler_unit_defines.svh"

module multicore_round_robin_scheduler_unit #(
  parameter int unsigned MAX_CORES = 4,
  parameter int unsigned MAX_TASKS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // event channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [2:0]                     in_kind_i,
  input  wire logic [5:0]                     in_task_id_i,
  input  wire logic [1:0]                     in_core_i,
  input  wire logic [5:0]                     in_current_task_i,
  input  wire logic                           in_current_idle_i,
  // decision channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [5:0]                          out_next_task_o,
  output logic                                out_next_idle_o,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mrrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);

  localparam int unsigned CIW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int unsigned TAW    = $clog2(MAX_TASKS);
  localparam int unsigned HW     = TAW;
  localparam int unsigned CNTW   = $clog2(MAX_TASKS + 1);
  localparam int unsigned QDEPTH = MAX_CORES * MAX_TASKS;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [CNTW-1:0] active;
    logic [CNTW-1:0] count;
    logic [HW-1:0]   head;
    logic [15:0]     quantum;
  } core_rec_t;

  // Tail position of a circular queue.
  function automatic logic [HW-1:0] tail_pos(logic [HW-1:0] head, logic [CNTW-1:0] cnt);
    logic [CNTW:0] sum;
    sum = (CNTW+1)'(head) + (CNTW+1)'(cnt);
    if (32'(sum) >= MAX_TASKS) begin
      return HW'(sum - (CNTW+1)'(MAX_TASKS));
    end
    return HW'(sum);
  endfunction

  function automatic logic [QAW-1:0] q_addr(logic [CIW-1:0] core, logic [HW-1:0] pos);
    return QAW'(32'(core) * MAX_TASKS) + QAW'(pos);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  mrrs_pkg::state_e state_q, state_d;

  logic [2:0]      num_cores_q;
  logic [15:0]     max_quantum_q;
  logic [TAW-1:0]  clr_q, clr_d;
  logic [CIW-1:0]  scan_q, scan_d;
  logic [CIW-1:0]  best_q, best_d;
  core_rec_t       best_rec_q, best_rec_d;

  logic [2:0]      kind_q;
  logic [5:0]      tid_q;
  logic [1:0]      core_q;
  logic [5:0]      cur_q;
  logic            cur_idle_q;

  logic            res_idle_q, res_idle_d;
  logic            res_mem_q, res_mem_d;
  logic [5:0]      res_task_q, res_task_d;

  logic            out_valid_q;
  logic [5:0]      out_task_q;
  logic            out_idle_q;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  core_rec_t       core_mem [MAX_CORES];
  logic [MAX_CORES-1:0] core_vld_q;
  core_rec_t       core_rd_q;
  logic            core_rd_vld_q;
  logic            core_re, core_we;
  logic [CIW-1:0]  core_raddr, core_waddr;
  core_rec_t       core_wdata;

  logic [CIW-1:0]  map_mem [MAX_TASKS];
  logic [CIW-1:0]  map_rd_q;
  logic            map_re, map_we;
  logic [TAW-1:0]  map_raddr, map_waddr;
  logic [CIW-1:0]  map_wdata;

  logic [5:0]      q_mem [QDEPTH];
  logic [5:0]      q_rd_q;
  logic            q_re, q_we;
  logic [QAW-1:0]  q_raddr, q_waddr;
  logic [5:0]      q_wdata;

  // --------------------------------------------------------------------------
  // Event decode
  // --------------------------------------------------------------------------
  logic            in_acc, out_free;
  logic            in_tid_ok, in_core_ok, in_is_place, in_is_core;
  logic [CIW-1:0]  last_core;
  core_rec_t       rec_rst, rec_eff;
  logic            map_core_ok;

  assign in_stall_o  = (state_q != mrrs_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign in_tid_ok   = (32'(in_task_id_i) < MAX_TASKS);
  assign in_core_ok  = (32'(in_core_i) < MAX_CORES);
  assign in_is_place = (in_kind_i == mrrs_pkg::KIND_LOAD) ||
                       (in_kind_i == mrrs_pkg::KIND_UNBLOCK);
  assign in_is_core  = (in_kind_i == mrrs_pkg::KIND_TICK) ||
                       (in_kind_i == mrrs_pkg::KIND_BLOCK) ||
                       (in_kind_i == mrrs_pkg::KIND_EXIT);
  assign map_core_ok = (32'(map_rd_q) < MAX_CORES);

  always_comb begin
    if (num_cores_q == 3'd0) begin
      last_core = '0;
    end else if (32'(num_cores_q) >= MAX_CORES) begin
      last_core = CIW'(MAX_CORES - 1);
    end else begin
      last_core = CIW'(num_cores_q - 3'd1);
    end
  end

  always_comb begin
    rec_rst         = '0;
    rec_rst.quantum = mrrs_pkg::QUANTUM_RESET;
    rec_eff         = core_rd_vld_q ? core_rd_q : rec_rst;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrrs_pkg::S_CLEAR: begin
        if (clr_q == TAW'(MAX_TASKS - 1)) state_d = mrrs_pkg::S_IDLE;
      end
      mrrs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_is_place) begin
            if (!in_tid_ok) begin
              state_d = mrrs_pkg::S_IDLE;
            end else if (in_kind_i == mrrs_pkg::KIND_LOAD) begin
              state_d = mrrs_pkg::S_SCAN;
            end else begin
              state_d = mrrs_pkg::S_MAP;
            end
          end else if (in_is_core && in_core_ok) begin
            state_d = mrrs_pkg::S_CORE;
          end else begin
            state_d = mrrs_pkg::S_RES;
          end
        end
      end
      mrrs_pkg::S_SCAN: begin
        if (scan_q == last_core) state_d = mrrs_pkg::S_LOAD_WR;
      end
      mrrs_pkg::S_LOAD_WR: state_d = mrrs_pkg::S_IDLE;
      mrrs_pkg::S_MAP: begin
        state_d = map_core_ok ? mrrs_pkg::S_UNBLK : mrrs_pkg::S_IDLE;
      end
      mrrs_pkg::S_UNBLK: state_d = mrrs_pkg::S_IDLE;
      mrrs_pkg::S_CORE:  state_d = mrrs_pkg::S_RES;
      mrrs_pkg::S_RES: begin
        if (out_free) state_d = mrrs_pkg::S_IDLE;
      end
      default: state_d = mrrs_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory ports
  // --------------------------------------------------------------------------
  logic            push, push_ok, disp;
  logic [CNTW-1:0] cnt_after;
  logic            cur_ok;

  always_comb begin
    clr_d      = clr_q;
    scan_d     = scan_q;
    best_d     = best_q;
    best_rec_d = best_rec_q;
    res_idle_d = res_idle_q;
    res_mem_d  = res_mem_q;
    res_task_d = res_task_q;

    core_re    = 1'b0;
    core_raddr = '0;
    core_we    = 1'b0;
    core_waddr = '0;
    core_wdata = rec_eff;
    map_re     = 1'b0;
    map_raddr  = TAW'(in_task_id_i);
    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    q_re       = 1'b0;
    q_raddr    = '0;
    q_we       = 1'b0;
    q_waddr    = '0;
    q_wdata    = cur_q;

    push      = (kind_q == mrrs_pkg::KIND_TICK) && !cur_idle_q && (rec_eff.quantum == 16'd0);
    push_ok   = push && (32'(rec_eff.count) < MAX_TASKS);
    cnt_after = rec_eff.count + CNTW'(push_ok);
    disp      = (kind_q == mrrs_pkg::KIND_BLOCK) || (kind_q == mrrs_pkg::KIND_EXIT) ||
                ((kind_q == mrrs_pkg::KIND_TICK) && (cur_idle_q || rec_eff.quantum == 16'd0));
    cur_ok    = !cur_idle_q && (32'(cur_q) < MAX_TASKS);

    case (state_q)
      mrrs_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      mrrs_pkg::S_IDLE: begin
        res_idle_d = 1'b1;
        res_mem_d  = 1'b0;
        res_task_d = '0;
        if (in_acc && in_is_place && in_tid_ok) begin
          if (in_kind_i == mrrs_pkg::KIND_LOAD) begin
            core_re    = 1'b1;
            core_raddr = '0;
            scan_d     = '0;
          end else begin
            map_re = 1'b1;
          end
        end else if (in_acc && in_is_core && in_core_ok) begin
          core_re    = 1'b1;
          core_raddr = CIW'(in_core_i);
        end
      end
      mrrs_pkg::S_SCAN: begin
        // keep the first core on ties
        if (scan_q == '0 || rec_eff.active < best_rec_q.active) begin
          best_d     = scan_q;
          best_rec_d = rec_eff;
        end
        if (scan_q != last_core) begin
          core_re    = 1'b1;
          core_raddr = scan_q + 1'b1;
          scan_d     = scan_q + 1'b1;
        end
      end
      mrrs_pkg::S_LOAD_WR: begin
        core_we    = 1'b1;
        core_waddr = best_q;
        core_wdata = best_rec_q;
        if (32'(best_rec_q.count) < MAX_TASKS) begin
          q_we             = 1'b1;
          q_waddr          = q_addr(best_q, tail_pos(best_rec_q.head, best_rec_q.count));
          q_wdata          = tid_q;
          core_wdata.count = best_rec_q.count + 1'b1;
        end
        if (32'(best_rec_q.active) < MAX_TASKS) begin
          core_wdata.active = best_rec_q.active + 1'b1;
        end
        map_we    = 1'b1;
        map_waddr = TAW'(tid_q);
        map_wdata = best_q;
      end
      mrrs_pkg::S_MAP: begin
        if (map_core_ok) begin
          core_re    = 1'b1;
          core_raddr = map_rd_q;
        end
      end
      mrrs_pkg::S_UNBLK: begin
        if (32'(rec_eff.count) < MAX_TASKS) begin
          q_we             = 1'b1;
          q_waddr          = q_addr(map_rd_q, tail_pos(rec_eff.head, rec_eff.count));
          q_wdata          = tid_q;
          core_we          = 1'b1;
          core_waddr       = map_rd_q;
          core_wdata.count = rec_eff.count + 1'b1;
        end
      end
      mrrs_pkg::S_CORE: begin
        core_we    = 1'b1;
        core_waddr = CIW'(core_q);
        if (push_ok) begin
          q_we    = 1'b1;
          q_waddr = q_addr(CIW'(core_q), tail_pos(rec_eff.head, rec_eff.count));
        end
        if (kind_q == mrrs_pkg::KIND_EXIT) begin
          if (rec_eff.active != '0) core_wdata.active = rec_eff.active - 1'b1;
          if (cur_ok) begin
            map_we    = 1'b1;
            map_waddr = TAW'(cur_q);
          end
        end
        if (!disp) begin
          core_wdata.quantum = rec_eff.quantum - 16'd1;
          res_idle_d         = 1'b0;
          res_task_d         = cur_q;
        end else if (cnt_after != '0) begin
          res_idle_d = 1'b0;
          // the word just pushed into an empty queue is the head: forward it
          if (push_ok && rec_eff.count == '0) begin
            res_task_d = cur_q;
          end else begin
            q_re      = 1'b1;
            q_raddr   = q_addr(CIW'(core_q), rec_eff.head);
            res_mem_d = 1'b1;
          end
          core_wdata.head    = (32'(rec_eff.head) == MAX_TASKS - 1) ? '0
                                                                    : rec_eff.head + 1'b1;
          core_wdata.count   = cnt_after - 1'b1;
          core_wdata.quantum = max_quantum_q;
        end else begin
          core_wdata.count = cnt_after;
        end
      end
      mrrs_pkg::S_RES: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mrrs_pkg::S_CLEAR;
      clr_q         <= '0;
      scan_q        <= '0;
      core_vld_q    <= '0;
      core_rd_vld_q <= 1'b0;
      num_cores_q   <= mrrs_pkg::CORES_RESET;
      max_quantum_q <= mrrs_pkg::QUANTUM_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      if (core_we) core_vld_q[core_waddr] <= 1'b1;
      if (core_re) core_rd_vld_q <= core_vld_q[core_raddr];
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mrrs_pkg::REG_NUM_CORES) begin
          num_cores_q <= cfg_data_i[2:0];
        end else if (cfg_index_i == mrrs_pkg::REG_MAX_QUANTUM) begin
          max_quantum_q <= cfg_data_i;
        end
      end
      if (state_q == mrrs_pkg::S_RES && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers and memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_rec_q <= best_rec_d;
    res_idle_q <= res_idle_d;
    res_mem_q  <= res_mem_d;
    res_task_q <= res_task_d;
    if (in_acc) begin
      kind_q     <= in_kind_i;
      tid_q      <= in_task_id_i;
      core_q     <= in_core_i;
      cur_q      <= in_current_task_i;
      cur_idle_q <= in_current_idle_i;
    end
    if (state_q == mrrs_pkg::S_RES && out_free) begin
      out_idle_q <= res_idle_q;
      out_task_q <= res_mem_q ? q_rd_q : res_task_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_we) core_mem[core_waddr] <= core_wdata;
    if (core_re) core_rd_q <= core_mem[core_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd_q <= q_mem[q_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign out_next_task_o = out_task_q;
  assign out_next_idle_o = out_idle_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MRRS_ASSERT_NEXT(a_res_loaded, clk_i, rst_ni,
                    (state_q == mrrs_pkg::S_RES) && out_free, out_valid_o,
                    "pending decision was not presented")
  `MRRS_ASSERT_IMPL(a_idle_task_zero, clk_i, rst_ni,
                    out_valid_o && out_next_idle_o, out_next_task_o == 6'd0,
                    "idle decision carries a task")
  `MRRS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, core_we,
                    (32'(core_wdata.count) <= MAX_TASKS) &&
                    (32'(core_wdata.active) <= MAX_TASKS),
                    "core queue or active count above capacity")

endmodule

`default_nettype wire

/* sim/mrrs_decision_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler decision checker
// Watches the event, decision and register ports of the round-robin
// scheduler, keeps its own copy of the queues, quanta and task placement,
// and compares every decision the scheduler returns with the oldest one
// it predicted.
// ----------------------------------------------------------------------------
module mrrs_decision_checker
  import mrrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [2:0]           in_kind_i,
  input  logic [5:0]           in_task_id_i,
  input  logic [1:0]           in_core_i,
  input  logic [5:0]           in_current_task_i,
  input  logic                 in_current_idle_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [5:0]           out_next_task_i,
  input  logic                 out_next_idle_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   events_o,
  output int                   decisions_o
);

  localparam int unsigned CORES = 4;
  localparam int unsigned TASKS = 64;

  typedef struct packed {
    logic [5:0] next_task;
    logic       next_idle;
  } decision_t;

  logic [5:0]  ready_q        [CORES][TASKS];
  logic [5:0]  q_head         [CORES];
  logic [6:0]  q_fill         [CORES];
  logic [15:0] quantum        [CORES];
  logic [6:0]  active         [CORES];
  logic [1:0]  home_core      [TASKS];
  logic [2:0]  cores_in_use;
  logic [15:0] quantum_reload;
  decision_t   expected_decisions[$];
  int          mismatches;
  int          events;
  int          decisions;

  initial begin
    for (int c = 0; c < CORES; c++) begin
      q_head[c]  = '0;
      q_fill[c]  = '0;
      quantum[c] = QUANTUM_RESET;
      active[c]  = '0;
    end
    for (int t = 0; t < TASKS; t++) home_core[t] = '0;
    cores_in_use   = CORES_RESET;
    quantum_reload = QUANTUM_RESET;
    mismatches     = 0;
    events         = 0;
    decisions      = 0;
    mismatches_o   = 0;
    pending_o      = 0;
    events_o       = 0;
    decisions_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Drop the push when the queue is full.
  task automatic enqueue(input int unsigned c, input logic [5:0] t);
    logic [5:0] slot;
    if (q_fill[c] < TASKS) begin
      slot = q_head[c] + q_fill[c][5:0];
      ready_q[c][slot] = t;
      q_fill[c] = q_fill[c] + 7'd1;
    end
  endtask

  task automatic dispatch(input int unsigned c, output bit ran, output logic [5:0] t);
    ran = 1'b0;
    t   = '0;
    if (q_fill[c] != 0) begin
      t          = ready_q[c][q_head[c]];
      q_head[c]  = q_head[c] + 6'd1;
      q_fill[c]  = q_fill[c] - 7'd1;
      quantum[c] = quantum_reload;
      ran        = 1'b1;
    end
  endtask

  task automatic schedule_event(input logic [2:0] kind, input logic [5:0] tid,
                                input logic [1:0] core, input logic [5:0] cur,
                                input logic cur_idle);
    int unsigned span;
    int unsigned best;
    int unsigned c;
    bit          ran;
    logic [5:0]  nxt;
    decision_t   d;
    ran = 1'b0;
    nxt = '0;
    case (kind)
      KIND_LOAD: begin
        // Clamp the core count to the range the hardware has.
        span = (cores_in_use == 0) ? 1 : (cores_in_use > CORES) ? CORES : cores_in_use;
        best = 0;
        for (c = 1; c < span; c++)
          if (active[c] < active[best]) best = c;
        enqueue(best, tid);
        if (active[best] < TASKS) active[best] = active[best] + 7'd1;
        home_core[tid] = best[1:0];
      end
      KIND_UNBLOCK: enqueue(home_core[tid], tid);
      KIND_TICK: begin
        if (cur_idle) begin
          dispatch(core, ran, nxt);
        end else if (quantum[core] == 0) begin
          enqueue(core, cur);
          dispatch(core, ran, nxt);
        end else begin
          quantum[core] = quantum[core] - 16'd1;
          nxt = cur;
          ran = 1'b1;
        end
      end
      KIND_BLOCK: dispatch(core, ran, nxt);
      KIND_EXIT: begin
        if (active[core] != 0) active[core] = active[core] - 7'd1;
        if (!cur_idle) home_core[cur] = '0;
        dispatch(core, ran, nxt);
      end
      default: ;
    endcase
    if (kind != KIND_LOAD && kind != KIND_UNBLOCK) begin
      d.next_task = ran ? nxt : 6'd0;
      d.next_idle = !ran;
      expected_decisions.push_back(d);
    end
  endtask

  task automatic check_decision(input logic [5:0] got_task, input logic got_idle);
    decision_t want;
    if (expected_decisions.size() == 0) begin
      report_mismatch($sformatf("decision task=%0d idle=%0b with none expected",
                                got_task, got_idle));
      return;
    end
    want = expected_decisions.pop_front();
    decisions++;
    if (got_idle !== want.next_idle)
      report_mismatch($sformatf("next_idle got %0b want %0b", got_idle, want.next_idle));
    if (got_task !== want.next_task)
      report_mismatch($sformatf("next_task got %0d want %0d", got_task, want.next_task));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Retire first so a word accepted this edge cannot satisfy its own decision.
      if (out_valid_i && !out_stall_i) check_decision(out_next_task_i, out_next_idle_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_NUM_CORES:   cores_in_use   = cfg_data_i[2:0];
          REG_MAX_QUANTUM: quantum_reload = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_event(in_kind_i, in_task_id_i, in_core_i, in_current_task_i,
                       in_current_idle_i);
        events++;
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_decisions.size();
    events_o     <= events;
    decisions_o  <= decisions;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler testbench
// Drives directed and random scheduler events through the valid/stall
// channel under several core-count and quantum settings and idle patterns;
// a separate checker predicts and compares every decision.
// ----------------------------------------------------------------------------
module testbench;
  import mrrs_pkg::*;

  localparam logic [2:0]           KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0]           KIND_SPARE_MID = 3'd6;
  localparam logic [2:0]           KIND_SPARE_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3    = 2'd3;
  localparam int                   PHASES         = 8;
  localparam int                   PHASE_EVENTS   = 150;
  localparam int                   FILL_LOADS     = 70;
  localparam int                   SETTLE_CYCLES  = 10;
  localparam int                   TAIL_CYCLES    = 20;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic [2:0]           in_kind_i         = '0;
  logic [5:0]           in_task_id_i      = '0;
  logic [1:0]           in_core_i         = '0;
  logic [5:0]           in_current_task_i = '0;
  logic                 in_current_idle_i = 1'b0;
  logic                 out_stall_i       = 1'b0;
  logic                 cfg_valid_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [15:0]          cfg_data_i        = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [5:0]           out_next_task_o;
  logic                 out_next_idle_o;
  logic                 cfg_ready_o;

  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         reg_writes    = 0;
  int         mismatches;
  int         pending;
  int         events;
  int         decisions;
  logic [5:0] live_tasks[$];

  logic [15:0] phase_cores   [PHASES] = '{16'd4, 16'd1, 16'd2, 16'd3,
                                          16'd0, 16'hFFF7, 16'd5, 16'd4};
  logic [15:0] phase_quantum [PHASES] = '{16'd0, 16'd1, 16'd3, 16'hFFFF,
                                          16'd2, 16'd5, 16'd10, 16'd7};

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i)
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

  multicore_round_robin_scheduler_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_kind_i, .in_task_id_i, .in_core_i,
    .in_current_task_i, .in_current_idle_i,
    .out_valid_o, .out_stall_i, .out_next_task_o, .out_next_idle_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mrrs_decision_checker decision_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_kind_i, .in_task_id_i, .in_core_i,
    .in_current_task_i, .in_current_idle_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_next_task_i(out_next_task_o),
    .out_next_idle_i(out_next_idle_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending), .events_o(events),
    .decisions_o(decisions)
  );

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 87; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 87; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  // Hold the word until the scheduler takes it.
  task automatic post_event(input logic [2:0] kind, input logic [5:0] tid,
                            input logic [1:0] core, input logic [5:0] cur,
                            input logic cur_idle);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_kind_i         <= kind;
    in_task_id_i      <= tid;
    in_core_i         <= core;
    in_current_task_i <= cur;
    in_current_idle_i <= cur_idle;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain all decisions, then give event words with no decision time to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  function automatic logic [5:0] known_task();
    if (live_tasks.size() != 0 && $urandom_range(0, 9) < 7)
      return live_tasks[$urandom_range(0, live_tasks.size() - 1)];
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic random_event();
    int unsigned pick;
    logic [5:0]  tid;
    logic [5:0]  cur;
    logic [1:0]  core;
    logic        cur_idle;
    logic [2:0]  kind;
    pick     = $urandom_range(0, 99);
    cur      = known_task();
    core     = 2'($urandom_range(0, 3));
    cur_idle = ($urandom_range(0, 3) == 0);
    tid      = 6'($urandom_range(0, 63));
    if (pick < 25) begin
      kind = KIND_LOAD;
      live_tasks.push_back(tid);
      if (live_tasks.size() > 16) void'(live_tasks.pop_front());
    end else if (pick < 40) begin
      kind = KIND_UNBLOCK;
      tid  = known_task();
    end else if (pick < 72) begin
      kind = KIND_TICK;
    end else if (pick < 82) begin
      kind = KIND_BLOCK;
    end else if (pick < 94) begin
      kind = KIND_EXIT;
    end else begin
      kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    post_event(kind, tid, core, cur, cur_idle);
  endtask

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, placement ties, idle exit, cleared mapping.
    post_event(KIND_EXIT,    6'd0,  2'd2, 6'd0,  1'b1);
    post_event(KIND_LOAD,    6'd0,  2'd0, 6'd0,  1'b0);
    post_event(KIND_LOAD,    6'd63, 2'd3, 6'd63, 1'b1);
    post_event(KIND_LOAD,    6'd5,  2'd0, 6'd0,  1'b0);
    post_event(KIND_LOAD,    6'd6,  2'd0, 6'd0,  1'b0);
    post_event(KIND_LOAD,    6'd7,  2'd0, 6'd0,  1'b0);
    post_event(KIND_TICK,    6'd0,  2'd0, 6'd0,  1'b1);
    post_event(KIND_TICK,    6'd0,  2'd0, 6'd0,  1'b0);
    post_event(KIND_BLOCK,   6'd0,  2'd1, 6'd63, 1'b0);
    post_event(KIND_UNBLOCK, 6'd63, 2'd0, 6'd0,  1'b0);
    post_event(KIND_EXIT,    6'd0,  2'd3, 6'd6,  1'b0);
    post_event(KIND_UNBLOCK, 6'd6,  2'd3, 6'd0,  1'b0);
    post_event(KIND_EXIT,    6'd0,  2'd1, 6'd63, 1'b1);
    post_event(KIND_SPARE_LO, 6'd63, 2'd3, 6'd63, 1'b1);
    post_event(KIND_SPARE_MID, 6'd0, 2'd3, 6'd0,  1'b0);
    post_event(KIND_SPARE_HI, 6'd63, 2'd3, 6'd63, 1'b0);
    post_event(KIND_BLOCK,   6'd0,  2'd2, 6'd5,  1'b0);
    post_event(KIND_BLOCK,   6'd0,  2'd2, 6'd5,  1'b0);
    settle();

    // Directed: zero quantum, a block on an empty queue, expiry with a busy queue.
    write_reg(REG_MAX_QUANTUM, 16'd0);
    post_event(KIND_BLOCK, 6'd0, 2'd1, 6'd0,  1'b1);
    post_event(KIND_TICK,  6'd0, 2'd1, 6'd63, 1'b0);
    post_event(KIND_TICK,  6'd0, 2'd0, 6'd0,  1'b1);
    post_event(KIND_TICK,  6'd0, 2'd0, 6'd7,  1'b0);
    settle();

    // Overfill one core's queue and saturate its active count, then drain.
    set_idling(3);
    write_reg(REG_NUM_CORES, 16'd1);
    write_reg(REG_MAX_QUANTUM, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_3, 16'($urandom_range(0, 65535)));
    repeat (FILL_LOADS)
      post_event(KIND_LOAD, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    repeat (FILL_LOADS)
      post_event(KIND_BLOCK, 6'($urandom_range(0, 63)), 2'd0,
                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_idling(p % 4);
      write_reg(REG_NUM_CORES, phase_cores[p]);
      write_reg(REG_MAX_QUANTUM,
                (p == 6) ? 16'($urandom_range(0, 20)) : phase_quantum[p]);
      repeat (PHASE_EVENTS) random_event();
      settle();
    end

    set_idling(0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d scheduler events and checked %0d decisions over %0d register writes,",
             events, decisions, reg_writes);
    $display("covering every event kind, full-queue drops, quantum expiry and clamped core counts.");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
